>>> hdl/gsig_pkg.sv
// Shared types and constants for the grid skirt index generator.
// No dependencies; imported by every module in hdl/.
package gsig_pkg;

    localparam int MAX_GRID_DIMENSION = 256;
    localparam int IDX_W              = 17;
    localparam int DIM_W              = 9;
    localparam int CNT_W              = 8;
    localparam int QUAD_LEN           = 6;
    localparam int SLOT_CNT_W         = 3;
    localparam logic [DIM_W-1:0] DIM_RESET = 9'd65;

    typedef enum logic [2:0] {
        PHASE_GRID  = 3'd0,
        PHASE_NORTH = 3'd1,
        PHASE_SOUTH = 3'd2,
        PHASE_WEST  = 3'd3,
        PHASE_EAST  = 3'd4
    } phase_t;

    typedef struct packed {
        logic [QUAD_LEN-1:0][IDX_W-1:0] idx;
        logic                           end_list;
    } quad_t;

endpackage

>>> hdl/grid_skirt_index_generator.sv
// Latency: first index of a quad is offered the cycle after its item is taken.
// Throughput: six indices per item, one index per cycle on the result side while
//   result_stall is low; the next item is taken on the edge where the sixth index leaves.
// Reset: walk at the first grid quad, dimension 65; a dimension write also
//   restarts the walk. Depends on gsig_pkg, gsig_walker, gsig_serializer.
module grid_skirt_index_generator
    import gsig_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [DIM_W-1:0] cfg_wdata,
    input  logic             item_valid,
    output logic             item_stall,
    input  logic             restart,
    output logic             result_valid,
    input  logic             result_stall,
    output logic [IDX_W-1:0] vertex_index,
    output logic             last_of_quad,
    output logic             last_of_list
);

    quad_t quad;
    logic  busy;
    logic  accept;

    assign item_stall = busy;
    assign accept     = item_valid && !busy;

    gsig_walker u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step      (accept),
        .restart   (restart),
        .quad      (quad)
    );

    gsig_serializer u_ser (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (accept),
        .quad         (quad),
        .busy         (busy),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .vertex_index (vertex_index),
        .last_of_quad (last_of_quad),
        .last_of_list (last_of_list)
    );

endmodule

>>> hdl/gsig_walker.sv
// Walk state, dimension register and per-item quad computation.
// Depends on gsig_pkg.
module gsig_walker
    import gsig_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [DIM_W-1:0] cfg_wdata,
    input  logic             step,
    input  logic             restart,
    output quad_t            quad
);

    logic [DIM_W-1:0] dim_reg;
    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] rb_reg, rb_next;

    logic [DIM_W-1:0] eff_d;
    logic [CNT_W-1:0] last;
    logic [IDX_W-1:0] d17, last17, base, last_d, prod;
    phase_t           cur_phase;
    logic [CNT_W-1:0] cur_col, cur_row, n, mul_k;
    logic [IDX_W-1:0] cur_rb, k17, n17, i0;
    logic [IDX_W-1:0] g0, g1, s0, s1;
    logic [DIM_W-1:0] col_inc, row_inc;
    logic             skirt;
    logic             end_list;

    always_comb
    begin
        if (dim_reg < DIM_W'(2))
            eff_d = DIM_W'(2);
        else if ({1'b0, dim_reg} > (DIM_W+1)'(MAX_GRID_DIMENSION))
            eff_d = DIM_W'(MAX_GRID_DIMENSION);
        else
            eff_d = dim_reg;
    end

    assign last   = CNT_W'(eff_d - DIM_W'(1));
    assign d17    = IDX_W'(eff_d);
    assign last17 = IDX_W'(last);
    assign base   = d17 * d17;
    assign last_d = base - d17;

    assign cur_phase = restart ? PHASE_GRID : phase_reg;
    assign cur_col   = restart ? '0 : col_reg;
    assign cur_row   = restart ? '0 : row_reg;
    assign cur_rb    = restart ? '0 : rb_reg;

    assign n     = last - cur_col;
    assign k17   = IDX_W'(cur_col);
    assign n17   = IDX_W'(n);
    assign mul_k = (cur_phase == PHASE_WEST) ? n : cur_col;
    assign prod  = IDX_W'(mul_k) * d17;
    assign i0    = cur_rb + k17;

    assign col_inc = DIM_W'(cur_col) + DIM_W'(1);
    assign row_inc = DIM_W'(cur_row) + DIM_W'(1);

    // skirt corner indices
    always_comb
    begin
        skirt    = 1'b1;
        g0       = '0;
        g1       = '0;
        s0       = '0;
        s1       = '0;
        end_list = 1'b0;
        case (cur_phase)
            PHASE_NORTH:
            begin
                g0 = k17;
                g1 = k17 + IDX_W'(1);
                s0 = base + k17;
                s1 = s0 + IDX_W'(1);
            end
            PHASE_SOUTH:
            begin
                g0 = last_d + n17;
                g1 = g0 - IDX_W'(1);
                s0 = base + d17 + n17;
                s1 = s0 - IDX_W'(1);
            end
            PHASE_WEST:
            begin
                g0 = prod;
                g1 = prod - d17;
                s0 = base + (d17 << 1) + n17;
                s1 = s0 - IDX_W'(1);
            end
            PHASE_EAST:
            begin
                g0       = prod + last17;
                g1       = g0 + d17;
                s0       = base + (d17 << 1) + d17 + k17;
                s1       = s0 + IDX_W'(1);
                end_list = (col_inc == {1'b0, last});
            end
            default:
            begin
                skirt = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        quad.end_list = end_list;
        if (skirt)
        begin
            quad.idx[0] = g0;
            quad.idx[1] = s0;
            quad.idx[2] = s1;
            quad.idx[3] = g0;
            quad.idx[4] = s1;
            quad.idx[5] = g1;
        end
        else
        begin
            quad.idx[0] = i0;
            quad.idx[1] = i0 + d17 + IDX_W'(1);
            quad.idx[2] = i0 + d17;
            quad.idx[3] = i0;
            quad.idx[4] = i0 + IDX_W'(1);
            quad.idx[5] = i0 + d17 + IDX_W'(1);
        end
    end

    always_comb
    begin
        phase_next = cur_phase;
        col_next   = cur_col;
        row_next   = cur_row;
        rb_next    = cur_rb;
        if (skirt)
        begin
            col_next = CNT_W'(col_inc);
            if (col_inc >= {1'b0, last})
            begin
                col_next = '0;
                case (cur_phase)
                    PHASE_NORTH: phase_next = PHASE_SOUTH;
                    PHASE_SOUTH: phase_next = PHASE_WEST;
                    PHASE_WEST:  phase_next = PHASE_EAST;
                    default:
                    begin
                        phase_next = PHASE_GRID;
                        row_next   = '0;
                        rb_next    = '0;
                    end
                endcase
            end
        end
        else
        begin
            phase_next = PHASE_GRID;
            col_next   = CNT_W'(col_inc);
            if (col_inc >= {1'b0, last})
            begin
                col_next = '0;
                row_next = CNT_W'(row_inc);
                rb_next  = cur_rb + d17;
                if (row_inc >= {1'b0, last})
                begin
                    row_next   = '0;
                    rb_next    = '0;
                    phase_next = PHASE_NORTH;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg   <= DIM_RESET;
            phase_reg <= PHASE_GRID;
            col_reg   <= '0;
            row_reg   <= '0;
            rb_reg    <= '0;
        end
        else if (cfg_we)
        begin
            // new dimension: walk starts over
            dim_reg   <= cfg_wdata;
            phase_reg <= PHASE_GRID;
            col_reg   <= '0;
            row_reg   <= '0;
            rb_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            rb_reg    <= rb_next;
        end
    end

endmodule

>>> hdl/gsig_serializer.sv
// Six-slot result register: loads one quad, shifts out one index per cycle while result_stall is low.
// Depends on gsig_pkg.
module gsig_serializer
    import gsig_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  quad_t            quad,
    output logic             busy,
    input  logic             result_stall,
    output logic             result_valid,
    output logic [IDX_W-1:0] vertex_index,
    output logic             last_of_quad,
    output logic             last_of_list
);

    logic [QUAD_LEN-1:0][IDX_W-1:0] slot_reg;
    logic [SLOT_CNT_W-1:0]          cnt_reg;
    logic                           list_reg;
    logic                           take;
    logic                           final_beat;

    assign result_valid = (cnt_reg != '0);
    assign take         = result_valid && !result_stall;
    assign final_beat   = (cnt_reg == SLOT_CNT_W'(1));
    // can take a new item when empty or when the last index leaves this cycle
    assign busy         = result_valid && !(final_beat && take);

    assign vertex_index = slot_reg[0];
    assign last_of_quad = final_beat;
    assign last_of_list = final_beat && list_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (load)
            cnt_reg <= SLOT_CNT_W'(QUAD_LEN);
        else if (take)
            cnt_reg <= cnt_reg - SLOT_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg <= quad.idx;
            list_reg <= quad.end_list;
        end
        else if (take)
        begin
            for (int i = 0; i < QUAD_LEN - 1; i++)
                slot_reg[i] <= slot_reg[i+1];
        end
    end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// Testbench for grid_skirt_index_generator: directed table, then random walks.
// Indices checked against known rows or the walk predictor. Depends on gsig_pkg and the hdl/ RTL.
module tb
    import gsig_pkg::*;
();

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             quad_end;
        logic             list_end;
    } vtx_t;

    typedef struct packed {
        logic                           is_cfg;
        logic [DIM_W-1:0]               dim;
        logic                           rst;
        logic                           known;
        logic                           list_end;
        logic [QUAD_LEN-1:0][IDX_W-1:0] idx;
    } stim_row_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [DIM_W-1:0] cfg_wdata;
    logic             item_valid;
    logic             item_stall;
    logic             restart;
    logic             result_valid;
    logic             result_stall = 1'b0;
    logic [IDX_W-1:0] vertex_index;
    logic             last_of_quad;
    logic             last_of_list;

    grid_skirt_index_generator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .restart      (restart),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .vertex_index (vertex_index),
        .last_of_quad (last_of_quad),
        .last_of_list (last_of_list)
    );

    // walk predictor state
    logic [DIM_W-1:0] mdl_dim;
    phase_t           mdl_phase;
    logic [CNT_W-1:0] mdl_col;
    logic [CNT_W-1:0] mdl_row;
    logic [IDX_W-1:0] mdl_rowbase;

    vtx_t      pending_vtx [$];
    vtx_t      got_vtx;
    vtx_t      want_vtx;
    stim_row_t dir_tab [$];
    int        mismatches = 0;
    bit        no_idle = 1'b0;

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic void walk_home();
        mdl_phase   = PHASE_GRID;
        mdl_col     = '0;
        mdl_row     = '0;
        mdl_rowbase = '0;
    endfunction

    function automatic void walk_step(input logic rst,
                                      output logic [QUAD_LEN-1:0][IDX_W-1:0] q,
                                      output logic eol);
        int unsigned d, last, base, k, n, g0, g1, s0, s1, i0;
        d = mdl_dim;
        if (d < 2) d = 2;
        if (d > MAX_GRID_DIMENSION) d = MAX_GRID_DIMENSION;
        last = d - 1;
        base = d * d;
        eol  = 1'b0;
        if (rst) walk_home();
        k = mdl_col;
        n = last - k;
        g0 = 0; g1 = 0; s0 = 0; s1 = 0;
        case (mdl_phase)
            PHASE_NORTH:
            begin
                g0 = k; g1 = k + 1; s0 = base + k; s1 = base + k + 1;
            end
            PHASE_SOUTH:
            begin
                g0 = last * d + n; g1 = last * d + n - 1;
                s0 = base + d + n; s1 = base + d + n - 1;
            end
            PHASE_WEST:
            begin
                g0 = n * d; g1 = (n - 1) * d;
                s0 = base + 2 * d + n; s1 = base + 2 * d + n - 1;
            end
            PHASE_EAST:
            begin
                g0 = k * d + last; g1 = (k + 1) * d + last;
                s0 = base + 3 * d + k; s1 = base + 3 * d + k + 1;
                eol = (k + 1 == last);
            end
            default: ;
        endcase
        if (mdl_phase != PHASE_GRID)
        begin
            // skirt quad: g0, s0, s1, g0, s1, g1
            q[0] = g0[IDX_W-1:0]; q[1] = s0[IDX_W-1:0]; q[2] = s1[IDX_W-1:0];
            q[3] = g0[IDX_W-1:0]; q[4] = s1[IDX_W-1:0]; q[5] = g1[IDX_W-1:0];
            if (k + 1 >= last)
            begin
                mdl_col = '0;
                if (mdl_phase == PHASE_EAST) walk_home();
                else mdl_phase = phase_t'(mdl_phase + 3'd1);
            end
            else
            begin
                mdl_col = CNT_W'(k + 1);
            end
        end
        else
        begin
            i0 = mdl_rowbase + k;
            q[0] = i0[IDX_W-1:0];
            q[1] = IDX_W'(i0 + d + 1);
            q[2] = IDX_W'(i0 + d);
            q[3] = i0[IDX_W-1:0];
            q[4] = IDX_W'(i0 + 1);
            q[5] = IDX_W'(i0 + d + 1);
            mdl_phase = PHASE_GRID;
            if (k + 1 >= last)
            begin
                mdl_col = '0;
                if (mdl_row + 1 >= last)
                begin
                    walk_home();
                    mdl_phase = PHASE_NORTH;
                end
                else
                begin
                    mdl_row     = mdl_row + 1'b1;
                    mdl_rowbase = IDX_W'(mdl_rowbase + d);
                end
            end
            else
            begin
                mdl_col = CNT_W'(k + 1);
            end
        end
    endfunction

    function automatic stim_row_t cfg_row(input logic [DIM_W-1:0] v);
        stim_row_t r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.dim    = v;
        return r;
    endfunction

    function automatic stim_row_t item_row(input logic rst);
        stim_row_t r;
        r     = '0;
        r.rst = rst;
        return r;
    endfunction

    function automatic stim_row_t known_row(input logic rst,
                                            input int unsigned a0, a1, a2, a3, a4, a5,
                                            input logic eol);
        stim_row_t r;
        r          = '0;
        r.rst      = rst;
        r.known    = 1'b1;
        r.list_end = eol;
        r.idx[0] = a0[IDX_W-1:0]; r.idx[1] = a1[IDX_W-1:0]; r.idx[2] = a2[IDX_W-1:0];
        r.idx[3] = a3[IDX_W-1:0]; r.idx[4] = a4[IDX_W-1:0]; r.idx[5] = a5[IDX_W-1:0];
        return r;
    endfunction

    task automatic send_item(input logic rst, input logic known,
                             input logic [QUAD_LEN-1:0][IDX_W-1:0] fixed_q,
                             input logic fixed_eol);
        logic [QUAD_LEN-1:0][IDX_W-1:0] q;
        logic eol;
        vtx_t v;
        int j;
        if (!no_idle)
        begin
            while ($urandom_range(99) < 30)
            begin
                item_valid <= 1'b0;
                restart    <= 1'($urandom_range(1));
                @(posedge clk);
            end
        end
        item_valid <= 1'b1;
        restart    <= rst;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        // predictor always advances, even when the row carries its own answer
        walk_step(rst, q, eol);
        if (known)
        begin
            q   = fixed_q;
            eol = fixed_eol;
        end
        for (j = 0; j < QUAD_LEN; j++)
        begin
            v.idx      = q[j];
            v.quad_end = (j == QUAD_LEN - 1);
            v.list_end = eol && (j == QUAD_LEN - 1);
            pending_vtx.push_back(v);
        end
    endtask

    task automatic set_dim(input logic [DIM_W-1:0] v);
        item_valid <= 1'b0;
        while (pending_vtx.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_wdata <= DIM_W'($urandom);
        mdl_dim = v;
        walk_home();
    endtask

    task automatic note_mismatch(input string what, input vtx_t w, input vtx_t g);
        if (mismatches < 10)
            $display("%0t %s: index %0d/%0d quad %b/%b list %b/%b (expected/actual)",
                     $realtime, what, w.idx, g.idx, w.quad_end, g.quad_end,
                     w.list_end, g.list_end);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        result_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 30);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            got_vtx = {vertex_index, last_of_quad, last_of_list};
            if (pending_vtx.size() == 0)
            begin
                note_mismatch("unexpected index", '0, got_vtx);
            end
            else
            begin
                want_vtx = pending_vtx.pop_front();
                if (got_vtx !== want_vtx) note_mismatch("index mismatch", want_vtx, got_vtx);
            end
        end
    end

    initial
    begin
        int r, n_sent, cnt, pick;
        logic [DIM_W-1:0] dim;

        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_wdata  <= DIM_RESET;
        item_valid <= 1'b0;
        restart    <= 1'b0;
        mdl_dim = DIM_RESET;
        walk_home();

        // after reset, d = 65
        dir_tab.push_back(known_row(1'b0, 0, 66, 65, 0, 1, 66, 1'b0));
        dir_tab.push_back(known_row(1'b0, 1, 67, 66, 1, 2, 67, 1'b0));
        dir_tab.push_back(known_row(1'b1, 0, 66, 65, 0, 1, 66, 1'b0));
        // smallest grid: one grid quad, one quad per edge, then wrap
        dir_tab.push_back(cfg_row(9'd2));
        dir_tab.push_back(known_row(1'b0, 0, 3, 2, 0, 1, 3, 1'b0));
        dir_tab.push_back(known_row(1'b0, 0, 4, 5, 0, 5, 1, 1'b0));
        dir_tab.push_back(known_row(1'b0, 3, 7, 6, 3, 6, 2, 1'b0));
        dir_tab.push_back(known_row(1'b0, 2, 9, 8, 2, 8, 0, 1'b0));
        dir_tab.push_back(known_row(1'b0, 1, 10, 11, 1, 11, 3, 1'b1));
        dir_tab.push_back(known_row(1'b0, 0, 3, 2, 0, 1, 3, 1'b0));
        // restart while in the north skirt
        dir_tab.push_back(known_row(1'b1, 0, 3, 2, 0, 1, 3, 1'b0));
        // out-of-range dimensions clamp to 2 and 256
        dir_tab.push_back(cfg_row(9'd0));
        dir_tab.push_back(known_row(1'b0, 0, 3, 2, 0, 1, 3, 1'b0));
        dir_tab.push_back(cfg_row(9'd511));
        dir_tab.push_back(known_row(1'b0, 0, 257, 256, 0, 1, 257, 1'b0));
        dir_tab.push_back(item_row(1'b0));
        dir_tab.push_back(cfg_row(9'd257));
        dir_tab.push_back(item_row(1'b1));
        // d = 3: one full list, every edge two quads
        dir_tab.push_back(cfg_row(9'd3));
        for (r = 0; r < 12; r++) dir_tab.push_back(item_row(1'b0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].is_cfg) set_dim(dir_tab[i].dim);
            else send_item(dir_tab[i].rst, dir_tab[i].known, dir_tab[i].idx,
                           dir_tab[i].list_end);
        end

        n_sent = 0;
        while (n_sent < 300)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                dim = DIM_W'($urandom_range(2, 6));
                cnt = $urandom_range(10, 60);
            end
            else if (pick < 78)
            begin
                dim = DIM_W'($urandom_range(7, 20));
                cnt = $urandom_range(10, 40);
            end
            else if (pick < 86)
            begin
                dim = DIM_W'($urandom_range(1));
                cnt = $urandom_range(5, 20);
            end
            else if (pick < 93)
            begin
                // large grids are slow to walk: only a few quads each
                dim = DIM_W'($urandom_range(256, 511));
                cnt = $urandom_range(2, 6);
            end
            else
            begin
                dim = DIM_W'($urandom_range(21, 255));
                cnt = $urandom_range(2, 8);
            end
            set_dim(dim);
            for (r = 0; r < cnt; r++)
            begin
                no_idle = (n_sent >= 100) && (n_sent < 170);
                send_item($urandom_range(99) < 4, 1'b0, '0, 1'b0);
                n_sent++;
            end
        end
        item_valid <= 1'b0;
        no_idle = 1'b0;

        while (pending_vtx.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
        if (mismatches == 0 && pending_vtx.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
hdl/gsig_pkg.sv
hdl/gsig_walker.sv
hdl/gsig_serializer.sv
hdl/grid_skirt_index_generator.sv
test/tb.sv
